// File: rtl/core/ps2mc_pkg.sv
package ps2mc_pkg;

	localparam int RX_BITS = 8;
	localparam int SIZE_BITS = 13;
	localparam int CFG_INDEX_BITS = 2;
	localparam int SYNC_BIT = 3;
	localparam int LEFT_BIT = 0;
	localparam int RIGHT_BIT = 1;

	localparam int RESET_X = 512;
	localparam int RESET_Y = 384;
	localparam logic [SIZE_BITS-1:0] RESET_WIDTH = SIZE_BITS'(1024);
	localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = SIZE_BITS'(768);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SCREEN_WIDTH = 2'd0,
		CFG_SCREEN_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		POS_FIRST,
		POS_SECOND,
		POS_THIRD
	} byte_pos_t;

endpackage

// File: rtl/core/ps2_mouse_packet_cursor.sv
// A byte is accepted into the input stage and decoded from there; the last byte of a
// packet writes its result into the output register once that register has room.
// One byte per cycle (single input stage, output register) unless a final byte waits.
// Reset clears the packet position to the first byte, the cursor to 512 and 384
// (saturated to the coordinate range), and the screen size to 1024 by 768.
module ps2_mouse_packet_cursor
	import ps2mc_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [SIZE_BITS-1:0]      cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [RX_BITS-1:0]        rx_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [COORD_BITS-1:0]     cursor_x,
	output logic [COORD_BITS-1:0]     cursor_y,
	output logic                      left_button,
	output logic                      right_button
);

	localparam int COORD_MAX = (1 << COORD_BITS) - 1;
	localparam int SUM_BITS = COORD_BITS + 2;
	localparam int CMP_BITS = SIZE_BITS + COORD_BITS;
	localparam logic [COORD_BITS-1:0] X_INIT =
		COORD_BITS'((RESET_X > COORD_MAX) ? COORD_MAX : RESET_X);
	localparam logic [COORD_BITS-1:0] Y_INIT =
		COORD_BITS'((RESET_Y > COORD_MAX) ? COORD_MAX : RESET_Y);

	logic [SIZE_BITS-1:0]  width_q;
	logic [SIZE_BITS-1:0]  height_q;

	logic                  valid_s1;
	logic [RX_BITS-1:0]    byte_s1;

	byte_pos_t             pos_q;
	logic [RX_BITS-1:0]    first_byte_q;
	logic [RX_BITS-1:0]    second_byte_q;
	logic [COORD_BITS-1:0] x_pos_q;
	logic [COORD_BITS-1:0] y_pos_q;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] cursor_x_q;
	logic [COORD_BITS-1:0] cursor_y_q;
	logic                  left_q;
	logic                  right_q;

	logic                  completes;
	logic                  advance;
	logic [COORD_BITS-1:0] x_limit;
	logic [COORD_BITS-1:0] y_limit;
	logic [SIZE_BITS-1:0]  width_m1;
	logic [SIZE_BITS-1:0]  height_m1;
	logic [SUM_BITS-1:0]   x_sum;
	logic [SUM_BITS-1:0]   y_sum;
	logic [COORD_BITS-1:0] x_next;
	logic [COORD_BITS-1:0] y_next;

	assign cfg_ready = 1'b1;

	// A stage holding a non-final byte always moves; a final byte waits for room.
	assign completes = valid_s1 && (pos_q == POS_THIRD);
	assign advance = valid_s1 && (!completes || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign out_valid = out_valid_q;
	assign cursor_x = cursor_x_q;
	assign cursor_y = cursor_y_q;
	assign left_button = left_q;
	assign right_button = right_q;

	always_comb begin
		width_m1 = width_q - SIZE_BITS'(1);
		height_m1 = height_q - SIZE_BITS'(1);

		if (width_q == '0) begin
			x_limit = '0;
		end else if (CMP_BITS'(width_m1) > CMP_BITS'(COORD_MAX)) begin
			x_limit = COORD_BITS'(COORD_MAX);
		end else begin
			x_limit = COORD_BITS'(width_m1);
		end

		if (height_q == '0) begin
			y_limit = '0;
		end else if (CMP_BITS'(height_m1) > CMP_BITS'(COORD_MAX)) begin
			y_limit = COORD_BITS'(COORD_MAX);
		end else begin
			y_limit = COORD_BITS'(height_m1);
		end

		x_sum = {2'b00, x_pos_q}
			+ {{(SUM_BITS-RX_BITS){second_byte_q[RX_BITS-1]}}, second_byte_q};
		y_sum = {2'b00, y_pos_q}
			- {{(SUM_BITS-RX_BITS){byte_s1[RX_BITS-1]}}, byte_s1};

		if (x_sum[SUM_BITS-1]) begin
			x_next = '0;
		end else if (x_sum[SUM_BITS-2:0] > {1'b0, x_limit}) begin
			x_next = x_limit;
		end else begin
			x_next = x_sum[COORD_BITS-1:0];
		end

		if (y_sum[SUM_BITS-1]) begin
			y_next = '0;
		end else if (y_sum[SUM_BITS-2:0] > {1'b0, y_limit}) begin
			y_next = y_limit;
		end else begin
			y_next = y_sum[COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:  width_q <= cfg_data;
				CFG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_FIRST;
			first_byte_q <= '0;
			second_byte_q <= '0;
			x_pos_q <= X_INIT;
			y_pos_q <= Y_INIT;
		end else if (advance) begin
			unique case (pos_q)
				POS_FIRST: begin
					if (byte_s1[SYNC_BIT]) begin
						first_byte_q <= byte_s1;
						pos_q <= POS_SECOND;
					end
				end
				POS_SECOND: begin
					second_byte_q <= byte_s1;
					pos_q <= POS_THIRD;
				end
				POS_THIRD: begin
					pos_q <= POS_FIRST;
					x_pos_q <= x_next;
					y_pos_q <= y_next;
				end
				default: pos_q <= POS_FIRST;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && completes) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && completes) begin
			cursor_x_q <= x_next;
			cursor_y_q <= y_next;
			left_q <= first_byte_q[LEFT_BIT];
			right_q <= first_byte_q[RIGHT_BIT];
		end
	end

endmodule

// File: dv/tb_ps2_mouse_packet_cursor.sv
module tb_ps2_mouse_packet_cursor;
	import ps2mc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS = 12;
	localparam int COORD_MAX = (1 << COORD_BITS) - 1;
	localparam int RANDOM_BYTES = 750;
	localparam int PACKETS_PER_PHASE = 40;
	localparam int SETTLE_CYCLES = 6;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  left;
		logic                  right;
	} cursor_report_t;

	typedef struct packed {
		logic                 is_cfg;
		cfg_reg_t             target;
		logic [SIZE_BITS-1:0] value;
		logic                 pinned;
		cursor_report_t       report;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index = CFG_SCREEN_WIDTH;
	logic [SIZE_BITS-1:0]  cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [RX_BITS-1:0]    rx_byte = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [COORD_BITS-1:0] cursor_x;
	logic [COORD_BITS-1:0] cursor_y;
	logic                  left_button;
	logic                  right_button;

	ps2_mouse_packet_cursor #(
		.COORD_BITS(COORD_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cursor_x(cursor_x),
		.cursor_y(cursor_y),
		.left_button(left_button),
		.right_button(right_button)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Decoder state as the block should hold it.
	byte_pos_t            rx_pos = POS_FIRST;
	logic [7:0]           head_byte = '0;
	logic [7:0]           dx_byte = '0;
	int                   cur_x = (RESET_X > COORD_MAX) ? COORD_MAX : RESET_X;
	int                   cur_y = (RESET_Y > COORD_MAX) ? COORD_MAX : RESET_Y;
	logic [SIZE_BITS-1:0] width_cfg = RESET_WIDTH;
	logic [SIZE_BITS-1:0] height_cfg = RESET_HEIGHT;

	cursor_report_t reports_due[$];
	int             mismatches = 0;

	logic           pin_now = 1'b0;
	cursor_report_t pin_report = '0;
	logic           steady = 1'b0;
	logic           drift_right = 1'b0;
	logic           drift_down = 1'b0;
	stim_row_t      directed_rows[$];

	function automatic int axis_limit(logic [SIZE_BITS-1:0] size);
		int lim;
		lim = (size == 0) ? 0 : int'(size) - 1;
		if (lim > COORD_MAX)
			lim = COORD_MAX;
		return lim;
	endfunction

	function automatic int clamp_axis(int v, int hi);
		if (v < 0)
			return 0;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic take_rx_byte(logic [7:0] b, logic pinned, cursor_report_t fixed);
		int             dx;
		int             dy;
		cursor_report_t rep;
		case (rx_pos)
			POS_FIRST: begin
				if (b[SYNC_BIT]) begin
					head_byte = b;
					rx_pos = POS_SECOND;
				end
			end
			POS_SECOND: begin
				dx_byte = b;
				rx_pos = POS_THIRD;
			end
			default: begin
				dx = $signed(dx_byte);
				dy = $signed(b);
				rx_pos = POS_FIRST;
				cur_x = clamp_axis(cur_x + dx, axis_limit(width_cfg));
				cur_y = clamp_axis(cur_y - dy, axis_limit(height_cfg));
				rep.x = cur_x[COORD_BITS-1:0];
				rep.y = cur_y[COORD_BITS-1:0];
				rep.left = head_byte[LEFT_BIT];
				rep.right = head_byte[RIGHT_BIT];
				reports_due.push_back(pinned ? fixed : rep);
			end
		endcase
	endtask

	task automatic check_field(string what, logic [COORD_BITS-1:0] want,
			logic [COORD_BITS-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		cursor_report_t due;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected beat, expected none, got x=%0d y=%0d",
						$time, cursor_x, cursor_y);
				end else begin
					due = reports_due.pop_front();
					check_field("cursor_x", due.x, cursor_x);
					check_field("cursor_y", due.y, cursor_y);
					check_field("left_button", COORD_BITS'(due.left),
						COORD_BITS'(left_button));
					check_field("right_button", COORD_BITS'(due.right),
						COORD_BITS'(right_button));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SCREEN_WIDTH: width_cfg = cfg_data;
					CFG_SCREEN_HEIGHT: height_cfg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				take_rx_byte(rx_byte, pin_now, pin_report);
		end
	end

	// Mostly short gaps, a few long ones, none at all in steady phases.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	initial begin
		int gap;
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

	// Leaves valid high after the beat so that a following byte can go out back to back.
	task automatic send_byte(logic [7:0] b, logic pinned = 1'b0,
			cursor_report_t fixed = '0);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		pin_now <= pinned;
		pin_report <= fixed;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (reports_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t target, logic [SIZE_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= target;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [SIZE_BITS-1:0] pick_size();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return SIZE_BITS'(1);
			2: return SIZE_BITS'(4096);
			3: return '1;
			4, 5, 6: return SIZE_BITS'($urandom_range(1, 64));
			7, 8: return SIZE_BITS'($urandom_range(65, 4096));
			default: return SIZE_BITS'($urandom_range(4097, 8191));
		endcase
	endfunction

	function automatic logic [7:0] pick_delta(logic drift_up);
		if ($urandom_range(0, 9) < 3)
			return drift_up ? 8'h7F : 8'h80;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic stim_row_t rx_row(logic [7:0] b);
		stim_row_t row;
		row = '0;
		row.value = SIZE_BITS'(b);
		return row;
	endfunction

	function automatic stim_row_t report_row(logic [7:0] b, int x, int y, logic l, logic r);
		stim_row_t row;
		row = rx_row(b);
		row.pinned = 1'b1;
		row.report.x = COORD_BITS'(x);
		row.report.y = COORD_BITS'(y);
		row.report.left = l;
		row.report.right = r;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(cfg_reg_t target, logic [SIZE_BITS-1:0] value);
		stim_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.target = target;
		row.value = value;
		return row;
	endfunction

	initial begin
		int sent;
		int packets;
		// Bytes without the marker bit are dropped while the decoder waits for a first byte.
		directed_rows.push_back(rx_row(8'h00));
		directed_rows.push_back(rx_row(8'hF7));
		directed_rows.push_back(rx_row(8'h08));
		directed_rows.push_back(rx_row(8'h00));
		directed_rows.push_back(report_row(8'h00, 512, 384, 1'b0, 1'b0));
		directed_rows.push_back(rx_row(8'h09));
		directed_rows.push_back(rx_row(8'h7F));
		directed_rows.push_back(report_row(8'h80, 639, 512, 1'b1, 1'b0));
		directed_rows.push_back(rx_row(8'h0A));
		directed_rows.push_back(rx_row(8'h80));
		directed_rows.push_back(report_row(8'h7F, 511, 385, 1'b0, 1'b1));
		directed_rows.push_back(rx_row(8'hFF));
		directed_rows.push_back(rx_row(8'hFF));
		directed_rows.push_back(report_row(8'h01, 510, 384, 1'b1, 1'b1));
		// A zero screen size pins the cursor to the origin.
		directed_rows.push_back(cfg_row(CFG_SCREEN_WIDTH, 13'd0));
		directed_rows.push_back(cfg_row(CFG_SCREEN_HEIGHT, 13'd0));
		directed_rows.push_back(rx_row(8'h08));
		directed_rows.push_back(rx_row(8'h7F));
		directed_rows.push_back(report_row(8'h80, 0, 0, 1'b0, 1'b0));
		directed_rows.push_back(cfg_row(CFG_SCREEN_WIDTH, 13'd8191));
		directed_rows.push_back(cfg_row(CFG_SCREEN_HEIGHT, 13'd4097));
		directed_rows.push_back(rx_row(8'h0B));
		directed_rows.push_back(rx_row(8'h7F));
		directed_rows.push_back(report_row(8'h81, 127, 127, 1'b1, 1'b1));
		// Shrinking the width leaves the stored column alone until the next packet.
		directed_rows.push_back(cfg_row(CFG_SCREEN_WIDTH, 13'd1));
		directed_rows.push_back(cfg_row(CFG_SCREEN_HEIGHT, 13'd4096));
		directed_rows.push_back(rx_row(8'h08));
		directed_rows.push_back(rx_row(8'h00));
		directed_rows.push_back(report_row(8'h00, 0, 127, 1'b0, 1'b0));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_idle();
				write_cfg(directed_rows[i].target, directed_rows[i].value);
			end else begin
				send_byte(directed_rows[i].value[7:0], directed_rows[i].pinned,
					directed_rows[i].report);
			end
		end

		sent = 0;
		packets = 0;
		while (sent < RANDOM_BYTES) begin
			if (packets % PACKETS_PER_PHASE == 0) begin
				wait_idle();
				if ($urandom_range(0, 3) != 0)
					write_cfg(CFG_SCREEN_WIDTH, pick_size());
				if ($urandom_range(0, 3) != 0)
					write_cfg(CFG_SCREEN_HEIGHT, pick_size());
				steady = ($urandom_range(0, 4) == 0);
				drift_right = 1'($urandom_range(0, 1));
				drift_down = 1'($urandom_range(0, 1));
			end
			// Stray bytes knock the framing out of step now and then.
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			send_byte(8'($urandom_range(0, 255)) | 8'h08);
			send_byte(pick_delta(drift_right));
			send_byte(pick_delta(!drift_down));
			sent += 3;
			packets++;
		end

		in_valid <= 1'b0;
		while (reports_due.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("ps2_mouse_packet_cursor verification clean");
		else
			$display("ps2_mouse_packet_cursor verification failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("ps2_mouse_packet_cursor verification failed");
		$finish;
	end

endmodule
